FILE: rtl/core/olpt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the online perceptron trainer.
// No dependencies; used by rtl/core/online_perceptron_trainer.sv.
package olpt_pkg;

	// Command codes of an input item.
	localparam logic [1:0] CMD_FEATURE = 2'd0;
	localparam logic [1:0] CMD_RESTORE = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_MODE    = 3'd0;
	localparam logic [2:0] CFG_RATE    = 3'd1;
	localparam logic [2:0] CFG_MARGIN  = 3'd2;
	localparam logic [2:0] CFG_NOLEARN = 3'd3;
	localparam logic [2:0] CFG_INIT    = 3'd4;

	// Update modes. The unused code behaves as the margin mode.
	localparam logic [1:0] MODE_SIMPLE = 2'd0;
	localparam logic [1:0] MODE_MARGIN = 2'd1;
	localparam logic [1:0] MODE_AGGR   = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Result kinds.
	localparam logic KIND_CLASS = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Register reset values.
	localparam logic [16:0] RATE_RESET   = 17'd6554;
	localparam logic [14:0] MARGIN_RESET = 15'd4096;

	// Aggressive step division: 57-bit dividend, one quotient bit per cycle.
	localparam int DIV_STEPS = 57;

	localparam int ST_N = 11;
	typedef enum logic [ST_N-1:0] {
		S_SWEEP  = 11'b000_0000_0001,
		S_IDLE   = 11'b000_0000_0010,
		S_FMUL   = 11'b000_0000_0100,
		S_FACC   = 11'b000_0000_1000,
		S_DECIDE = 11'b000_0001_0000,
		S_DIV    = 11'b000_0010_0000,
		S_UREAD  = 11'b000_0100_0000,
		S_UMUL   = 11'b000_1000_0000,
		S_UWRITE = 11'b001_0000_0000,
		S_RDATA  = 11'b010_0000_0000,
		S_EMIT   = 11'b100_0000_0000
	} state_t;

endpackage

FILE: rtl/core/online_perceptron_trainer.sv
`timescale 1ns / 1ps
// Online perceptron trainer top level: weight and example memories, accumulators,
// step divider and weight update walk. Depends on rtl/core/olpt_pkg.sv.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    cmd, feature_value, label, last_feature,
//                                             weight_index
// out       output     out_valid / out_ready  result_kind, mistake, mistake_count,
//                                             weight_value
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// A feature item with buffer room passes through weight memory read, multiply and
// accumulate. A read item reads the weight memory, registers the weight and then
// waits for the output slot. Closing an example adds a decision state; on an update,
// aggressive mode first runs the bit-serial divider, then the walk takes each
// buffered feature through memory read, step multiply and saturating write-back.
// After reset, and after every restore item, the weight memory is swept entry by
// entry; no item is accepted then. Configuration writes are always taken. A stalled
// output holds its item; the block waits to emit.
module online_perceptron_trainer #(
	parameter int MAX_FEATURES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] feature_value,
	input  logic signed [1:0]  label,
	input  logic               last_feature,
	input  logic [6:0]         weight_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic               mistake,
	output logic [23:0]        mistake_count,
	output logic signed [31:0] weight_value,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [21:0]        cfg_data
);

	localparam int AW = $clog2(MAX_FEATURES);
	localparam int PW = $clog2(MAX_FEATURES + 1);
	localparam int IW = (AW > 7) ? AW : 7;

	// Configuration registers.
	logic [1:0]  mode_q;
	logic [16:0] rate_q;
	logic [14:0] margin_q;
	logic        nolearn_q;
	logic [21:0] init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= olpt_pkg::MODE_SIMPLE;
			rate_q    <= olpt_pkg::RATE_RESET;
			margin_q  <= olpt_pkg::MARGIN_RESET;
			nolearn_q <= 1'b0;
			init_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				olpt_pkg::CFG_MODE:    mode_q    <= cfg_data[1:0];
				olpt_pkg::CFG_RATE:    rate_q    <= cfg_data[16:0];
				olpt_pkg::CFG_MARGIN:  margin_q  <= cfg_data[14:0];
				olpt_pkg::CFG_NOLEARN: nolearn_q <= cfg_data[0];
				olpt_pkg::CFG_INIT:    init_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control and datapath registers.
	olpt_pkg::state_t state_q;
	logic [AW-1:0]        sw_q;
	logic signed [31:0]   fill_q;
	logic [PW-1:0]        pos_q;
	logic [PW-1:0]        k_q;
	logic signed [47:0]   dot_q;
	logic [39:0]          norm_q;
	logic [23:0]          cnt_q;
	logic [5:0]           dcnt_q;
	logic [40:0]          rem_q;
	logic [56:0]          quo_q;
	logic [33:0]          step_q;
	logic signed [15:0]   f_q;
	logic signed [1:0]    label_q;
	logic                 last_q;
	logic                 idx_ok_q;
	logic                 pend_kind_q;
	logic                 pend_mistake_q;
	logic signed [31:0]   pend_weight_q;
	logic signed [47:0]   prod_s1;
	logic [30:0]          sq_s1;
	logic [49:0]          mag_s1;
	logic                 neg_s1;
	logic signed [31:0]   w_s1;
	logic                 out_valid_q;
	logic                 kind_q;
	logic                 mistake_q;
	logic [23:0]          count_q;
	logic signed [31:0]   weight_q;

	// Weight memory and example buffer, one write and one read port each.
	logic signed [31:0] wmem [MAX_FEATURES];
	logic signed [15:0] ebuf [MAX_FEATURES];
	logic signed [31:0] w_rd_q;
	logic signed [15:0] e_rd_q;
	logic               w_we;
	logic [AW-1:0]      w_waddr;
	logic signed [31:0] w_wdata;
	logic [AW-1:0]      w_raddr;
	logic               e_we;

	logic [IW-1:0] idx_w;
	logic          accept;
	logic          out_free;
	logic          emit;
	logic          pos_room;

	assign idx_w    = IW'(weight_index);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	// The pending result moves into the output register in this cycle.
	assign emit     = (state_q == olpt_pkg::S_EMIT) && out_free;
	assign pos_room = 32'(pos_q) < MAX_FEATURES;
	assign in_ready = (state_q == olpt_pkg::S_IDLE);
	assign e_we     = accept && (cmd == olpt_pkg::CMD_FEATURE) && pos_room;

	always_comb begin
		case (state_q)
			olpt_pkg::S_UREAD: w_raddr = k_q[AW-1:0];
			default:           w_raddr = (cmd == olpt_pkg::CMD_READ) ? idx_w[AW-1:0]
			                                                        : pos_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_waddr] <= w_wdata;
		end
		w_rd_q <= wmem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			ebuf[pos_q[AW-1:0]] <= feature_value;
		end
		e_rd_q <= ebuf[k_q[AW-1:0]];
	end

	// Accumulator sums with saturation.
	logic signed [48:0] dot_sum;
	logic signed [47:0] dot_next;
	logic [40:0]        norm_sum;
	logic [39:0]        norm_next;
	logic signed [31:0] sq_full;

	always_comb begin
		dot_sum  = 49'(dot_q) + 49'(prod_s1);
		if (dot_sum[48] != dot_sum[47]) begin
			dot_next = dot_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end else begin
			dot_next = dot_sum[47:0];
		end
		norm_sum  = 41'(norm_q) + 41'(sq_s1);
		norm_next = norm_sum[40] ? {40{1'b1}} : norm_sum[39:0];
		sq_full   = 32'(f_q) * 32'(f_q);
	end

	// Score, threshold and the aggressive step dividend.
	logic signed [49:0] dot_x;
	logic signed [49:0] score;
	logic signed [49:0] thr;
	logic signed [49:0] diff;
	logic               is_mistake;
	logic               do_update;

	always_comb begin
		dot_x = 50'(dot_q);
		case (label_q)
			2'b01:   score = dot_x;
			2'b11:   score = -dot_x;
			2'b10:   score = -(dot_x <<< 1);
			default: score = '0;
		endcase
		thr        = (mode_q == olpt_pkg::MODE_SIMPLE) ? '0
		             : $signed({15'b0, margin_q, 20'b0});
		diff       = thr - score;
		is_mistake = score <= thr;
		do_update  = is_mistake && !nolearn_q;
	end

	// One restoring division step.
	logic [41:0] div_sh;
	logic [41:0] div_den;
	logic        div_ge;

	always_comb begin
		div_sh  = {rem_q, quo_q[56]};
		div_den = 42'(norm_q) + 42'(25'h100_0000);
		div_ge  = div_sh >= div_den;
	end

	// Weight update with rounding and saturation.
	logic [15:0]        abs_x;
	logic [50:0]        mag_rnd;
	logic [42:0]        delta;
	logic signed [43:0] w_upd;
	logic signed [31:0] w_sat;

	always_comb begin
		abs_x   = e_rd_q[15] ? 16'(-e_rd_q) : 16'(e_rd_q);
		mag_rnd = 51'(mag_s1) + 51'(8'd128);
		delta   = mag_rnd[50:8];
		w_upd   = neg_s1 ? (44'(w_s1) - $signed({1'b0, delta}))
		                 : (44'(w_s1) + $signed({1'b0, delta}));
		if (w_upd > 44'sh0_7FFF_FFFF) begin
			w_sat = 32'sh7FFF_FFFF;
		end else if (w_upd < -44'sh0_8000_0000) begin
			w_sat = 32'sh8000_0000;
		end else begin
			w_sat = w_upd[31:0];
		end
	end

	always_comb begin
		w_we    = 1'b0;
		w_waddr = sw_q;
		w_wdata = fill_q;
		case (state_q)
			olpt_pkg::S_SWEEP: w_we = 1'b1;
			olpt_pkg::S_UWRITE: begin
				w_we    = 1'b1;
				w_waddr = k_q[AW-1:0];
				w_wdata = w_sat;
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olpt_pkg::S_SWEEP;
			sw_q        <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			dot_q       <= '0;
			norm_q      <= '0;
			cnt_q       <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !out_ready);
			case (state_q)
				olpt_pkg::S_SWEEP: begin
					if (sw_q == AW'(MAX_FEATURES - 1)) begin
						sw_q    <= '0;
						state_q <= olpt_pkg::S_IDLE;
					end else begin
						sw_q <= sw_q + 1'b1;
					end
				end
				olpt_pkg::S_IDLE: begin
					if (accept) begin
						case (cmd)
							olpt_pkg::CMD_FEATURE: begin
								if (pos_room) begin
									state_q <= olpt_pkg::S_FMUL;
								end else if (last_feature) begin
									state_q <= olpt_pkg::S_DECIDE;
								end
							end
							olpt_pkg::CMD_RESTORE: begin
								fill_q  <= {{10{init_q[21]}}, init_q};
								cnt_q   <= '0;
								pos_q   <= '0;
								dot_q   <= '0;
								norm_q  <= '0;
								state_q <= olpt_pkg::S_SWEEP;
							end
							olpt_pkg::CMD_READ: state_q <= olpt_pkg::S_RDATA;
							default: ;
						endcase
					end
				end
				olpt_pkg::S_FMUL: state_q <= olpt_pkg::S_FACC;
				olpt_pkg::S_FACC: begin
					dot_q   <= dot_next;
					norm_q  <= norm_next;
					pos_q   <= pos_q + 1'b1;
					state_q <= last_q ? olpt_pkg::S_DECIDE : olpt_pkg::S_IDLE;
				end
				olpt_pkg::S_DECIDE: begin
					if (is_mistake && cnt_q != 24'hFF_FFFF) begin
						cnt_q <= cnt_q + 1'b1;
					end
					k_q    <= '0;
					dcnt_q <= '0;
					if (!do_update) begin
						state_q <= olpt_pkg::S_EMIT;
					end else if (mode_q == olpt_pkg::MODE_AGGR) begin
						state_q <= olpt_pkg::S_DIV;
					end else begin
						state_q <= (pos_q == '0) ? olpt_pkg::S_EMIT : olpt_pkg::S_UREAD;
					end
				end
				olpt_pkg::S_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'(olpt_pkg::DIV_STEPS - 1)) begin
						state_q <= (pos_q == '0) ? olpt_pkg::S_EMIT : olpt_pkg::S_UREAD;
					end
				end
				olpt_pkg::S_UREAD: state_q <= olpt_pkg::S_UMUL;
				olpt_pkg::S_UMUL:  state_q <= olpt_pkg::S_UWRITE;
				olpt_pkg::S_UWRITE: begin
					k_q <= k_q + 1'b1;
					state_q <= (PW'(k_q + 1'b1) == pos_q) ? olpt_pkg::S_EMIT
					                                       : olpt_pkg::S_UREAD;
				end
				olpt_pkg::S_RDATA: state_q <= olpt_pkg::S_EMIT;
				olpt_pkg::S_EMIT: begin
					if (out_free) begin
						if (pend_kind_q == olpt_pkg::KIND_CLASS) begin
							pos_q  <= '0;
							dot_q  <= '0;
							norm_q <= '0;
						end
						state_q <= olpt_pkg::S_IDLE;
					end
				end
				default: state_q <= olpt_pkg::S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			f_q      <= feature_value;
			label_q  <= label;
			last_q   <= last_feature;
			idx_ok_q <= 32'(weight_index) < MAX_FEATURES;
		end
		if (state_q == olpt_pkg::S_FMUL) begin
			prod_s1 <= w_rd_q * f_q;
			sq_s1   <= sq_full[30:0];
		end
		if (state_q == olpt_pkg::S_DECIDE) begin
			pend_kind_q    <= olpt_pkg::KIND_CLASS;
			pend_mistake_q <= is_mistake;
			pend_weight_q  <= '0;
			step_q         <= 34'(rate_q);
			rem_q          <= '0;
			quo_q          <= {diff[48:0], 8'b0};
		end
		if (state_q == olpt_pkg::S_DIV) begin
			rem_q <= div_ge ? 41'(div_sh - div_den) : div_sh[40:0];
			quo_q <= {quo_q[55:0], div_ge};
			if (dcnt_q == 6'(olpt_pkg::DIV_STEPS - 1)) begin
				step_q <= {quo_q[32:0], div_ge};
			end
		end
		if (state_q == olpt_pkg::S_UMUL) begin
			mag_s1 <= 50'(step_q) * 50'(abs_x);
			neg_s1 <= e_rd_q[15] != (label_q != 2'b01);
			w_s1   <= w_rd_q;
		end
		if (state_q == olpt_pkg::S_RDATA) begin
			pend_kind_q    <= olpt_pkg::KIND_READ;
			pend_mistake_q <= 1'b0;
			pend_weight_q  <= idx_ok_q ? w_rd_q : '0;
		end
		if (emit) begin
			kind_q    <= pend_kind_q;
			mistake_q <= pend_mistake_q;
			count_q   <= cnt_q;
			weight_q  <= pend_weight_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign mistake       = mistake_q;
	assign mistake_count = count_q;
	assign weight_value  = weight_q;

	// The position never passes the buffer depth.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= MAX_FEATURES)
		else $error("feature position beyond buffer depth");

	// The update walk only touches entries of the current example.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == olpt_pkg::S_UWRITE) |-> (k_q < pos_q))
		else $error("weight update outside the example");

	// A result is only loaded into a free output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == olpt_pkg::S_EMIT && out_valid_q && !out_ready) |=> out_valid_q
		&& (state_q == olpt_pkg::S_EMIT))
		else $error("result emitted over a stalled item");

	// No item is taken during the memory sweep.
	a_sweep_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == olpt_pkg::S_SWEEP) |-> !in_ready)
		else $error("item accepted during sweep");

endmodule
